// ===== rtl/serial_packet_receiver_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef SERIAL_PACKET_RECEIVER_DEFINES_SVH
`define SERIAL_PACKET_RECEIVER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spr check failed");

// Antecedent implies consequent in the next cycle.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spr check failed");

`endif

// ===== rtl/spr_pkg.sv =====
package spr_pkg;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ENQ = 8'h05;

    localparam int HEADER_LEN = 7;
    localparam logic [8:0] HEADER_LAST = 9'(HEADER_LEN - 1);

    // Header byte positions
    localparam logic [8:0] POS_DEST   = 9'd2;
    localparam logic [8:0] POS_SOURCE = 9'd3;
    localparam logic [8:0] POS_FUNC   = 9'd4;
    localparam logic [8:0] POS_SIZE   = 9'd5;

    localparam logic [2:0] ERR_BAD_SOH    = 3'd0;
    localparam logic [2:0] ERR_HDR_SUM    = 3'd1;
    localparam logic [2:0] ERR_NOT_ADDR   = 3'd2;
    localparam logic [2:0] ERR_BAD_STX    = 3'd3;
    localparam logic [2:0] ERR_BAD_ETX    = 3'd4;
    localparam logic [2:0] ERR_DATA_SUM   = 3'd5;
    localparam logic [2:0] ERR_BAD_EOT    = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_DATA    = 3'd2,
        PH_CHECK   = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       send_ack;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       packet_done;
        logic       packet_error;
        logic [2:0] error_code;
        logic [7:0] source_id;
        logic [7:0] function_code;
        logic [8:0] payload_length;
    } result_t;

endpackage

// ===== rtl/serial_packet_receiver.sv =====
// Path: input register, per-byte state update, result register; a held result keeps
// the next byte waiting in the input register.
// Throughput: one byte per cycle unless the result side stalls.
// Each accepted byte produces exactly one result item.
// Reset (aresetn low, synchronous): phase idle, counters, sums, header fields and
// station_id cleared to zero, both stages empty; no clearing pass.
module serial_packet_receiver
    import spr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_send_ack,
    output logic       m_data_valid,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_data_index,
    output logic       m_packet_done,
    output logic       m_packet_error,
    output logic [2:0] m_error_code,
    output logic [7:0] m_source_id,
    output logic [7:0] m_function_code,
    output logic [8:0] m_payload_length
);

    in_item_t item;
    logic     advance;
    result_t  result;

    assign cfg_ready = 1'b1;

    spr_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .item      (item)
    );

    spr_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .advance   (advance),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_send_ack       = result.send_ack;
    assign m_data_valid     = result.data_valid;
    assign m_data_byte      = result.data_byte;
    assign m_data_index     = result.data_index;
    assign m_packet_done    = result.packet_done;
    assign m_packet_error   = result.packet_error;
    assign m_error_code     = result.error_code;
    assign m_source_id      = result.source_id;
    assign m_function_code  = result.function_code;
    assign m_payload_length = result.payload_length;

endmodule

// ===== rtl/spr_in_stage.sv =====
module spr_in_stage
    import spr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output in_item_t   item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Free slot, or the held item leaves this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            byte_next  = s_rx_byte;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

// ===== rtl/spr_framer.sv =====
module spr_framer
    import spr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   item,
    output logic       advance,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    result
);

    phase_t     phase_reg, phase_next;
    logic [8:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] start_reg, start_next;
    logic [7:0] dest_reg, dest_next;
    logic [7:0] source_reg, source_next;
    logic [7:0] func_reg, func_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] station_reg;

    logic       out_valid_reg;
    result_t    out_reg, out_next;

    logic [7:0] b;
    logic       first;
    logic [7:0] start_eff;
    logic [7:0] sum_eff;
    logic       hdr_last;
    logic       data_last;
    logic       chk_last;
    logic       hdr_fail;
    logic [2:0] hdr_code;
    logic       chk_fail;
    logic [2:0] chk_code;

    // Move the input item into the result register when that slot frees up
    assign advance = item.valid && (!out_valid_reg || m_ready);

    assign b         = item.rx_byte;
    assign first     = (count_reg == 9'd0);
    assign start_eff = first ? b : start_reg;
    // Header and data sections restart the sum; the check section continues it
    assign sum_eff   = ((first && (phase_reg == PH_HEADER || phase_reg == PH_DATA))
                        ? 8'd0 : sum_reg) + b;
    assign hdr_last  = (count_reg >= HEADER_LAST);
    assign data_last = (count_reg >= ({1'b0, size_reg} + 9'd1));
    assign chk_last  = (count_reg >= 9'd1);

    always_comb begin
        hdr_fail = 1'b1;
        hdr_code = ERR_BAD_SOH;
        priority if (start_eff != CH_SOH) begin
            hdr_code = ERR_BAD_SOH;
        end else if (sum_eff != 8'd0) begin
            hdr_code = ERR_HDR_SUM;
        end else if (dest_reg != station_reg) begin
            hdr_code = ERR_NOT_ADDR;
        end else begin
            hdr_fail = 1'b0;
        end
    end

    always_comb begin
        chk_fail = 1'b1;
        chk_code = ERR_BAD_ETX;
        priority if (start_eff != CH_ETX) begin
            chk_code = ERR_BAD_ETX;
        end else if (sum_eff != 8'd0) begin
            chk_code = ERR_DATA_SUM;
        end else begin
            chk_fail = 1'b0;
        end
    end

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        start_next  = start_reg;
        dest_next   = dest_reg;
        source_next = source_reg;
        func_next   = func_reg;
        size_next   = size_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                start_next = start_eff;
                sum_next   = sum_eff;
                count_next = count_reg + 9'd1;
                if (count_reg == POS_DEST) begin
                    dest_next = b;
                end
                if (count_reg == POS_SOURCE) begin
                    source_next = b;
                end
                if (count_reg == POS_FUNC) begin
                    func_next = b;
                end
                if (count_reg == POS_SIZE) begin
                    size_next = b;
                end
                if (hdr_last) begin
                    phase_next = hdr_fail ? PH_IDLE : PH_DATA;
                    count_next = 9'd0;
                end
            end
            PH_DATA: begin
                start_next = start_eff;
                sum_next   = sum_eff;
                count_next = count_reg + 9'd1;
                if (data_last) begin
                    phase_next = (start_eff != CH_STX) ? PH_IDLE : PH_CHECK;
                    count_next = 9'd0;
                end
            end
            PH_CHECK: begin
                start_next = start_eff;
                sum_next   = sum_eff;
                count_next = count_reg + 9'd1;
                if (chk_last) begin
                    phase_next = chk_fail ? PH_IDLE : PH_TRAILER;
                    count_next = 9'd0;
                end
            end
            PH_TRAILER: begin
                phase_next = PH_IDLE;
                count_next = 9'd0;
            end
            default: begin
                // Idle and unused codes: wait for an enquiry
                if (b == CH_ENQ) begin
                    phase_next = PH_HEADER;
                    count_next = 9'd0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // Result fields
    always_comb begin
        out_next = '0;
        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_last) begin
                    out_next.send_ack     = !hdr_fail;
                    out_next.packet_error = hdr_fail;
                    out_next.error_code   = hdr_fail ? hdr_code : 3'd0;
                end
            end
            PH_DATA: begin
                if (!first) begin
                    out_next.data_valid = 1'b1;
                    out_next.data_byte  = b;
                    out_next.data_index = count_reg[7:0] - 8'd1;
                end
                if (data_last && (start_eff != CH_STX)) begin
                    out_next.packet_error = 1'b1;
                    out_next.error_code   = ERR_BAD_STX;
                end
            end
            PH_CHECK: begin
                if (chk_last && chk_fail) begin
                    out_next.packet_error = 1'b1;
                    out_next.error_code   = chk_code;
                end
            end
            PH_TRAILER: begin
                if (b != CH_EOT) begin
                    out_next.packet_error = 1'b1;
                    out_next.error_code   = ERR_BAD_EOT;
                end else begin
                    out_next.send_ack       = 1'b1;
                    out_next.packet_done    = 1'b1;
                    out_next.source_id      = source_reg;
                    out_next.function_code  = func_reg;
                    out_next.payload_length = {1'b0, size_reg} + 9'd1;
                end
            end
            default: begin
                out_next.send_ack = (b == CH_ENQ);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            count_reg     <= 9'd0;
            sum_reg       <= 8'd0;
            start_reg     <= 8'd0;
            dest_reg      <= 8'd0;
            source_reg    <= 8'd0;
            func_reg      <= 8'd0;
            size_reg      <= 8'd0;
            station_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                station_reg <= cfg_data;
            end
            if (advance) begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                start_reg  <= start_next;
                dest_reg   <= dest_next;
                source_reg <= source_next;
                func_reg   <= func_next;
                size_reg   <= size_next;
            end
            // Hold a result until taken; refill in the same cycle it leaves
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

endmodule

// ===== rtl/spr_checker.sv =====
`include "serial_packet_receiver_defines.svh"

module spr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_send_ack,
    input logic       m_data_valid,
    input logic [7:0] m_data_byte,
    input logic [7:0] m_data_index,
    input logic       m_packet_done,
    input logic       m_packet_error,
    input logic [2:0] m_error_code
);

    // A stalled item holds its payload
    `SPR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data_byte) && $stable(m_error_code) && $stable(m_packet_done))

    // A packet is never both accepted and rejected on one byte
    `SPR_ASSERT_SAME(a_done_xor_err, aclk, aresetn, m_valid, !(m_packet_done && m_packet_error))

    // Completion is always acknowledged
    `SPR_ASSERT_SAME(a_done_ack, aclk, aresetn, m_valid && m_packet_done, m_send_ack && !m_data_valid)

    // Error code is zero unless an error is reported
    `SPR_ASSERT_SAME(a_code_clear, aclk, aresetn, m_valid && !m_packet_error, m_error_code == 3'd0)

    // Data fields are zero when no payload byte is carried
    `SPR_ASSERT_SAME(a_data_clear, aclk, aresetn, m_valid && !m_data_valid,
        m_data_byte == 8'd0 && m_data_index == 8'd0)

endmodule

bind serial_packet_receiver spr_checker u_spr_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
    import spr_pkg::*;

    typedef enum int {
        FAULT_NONE,
        FAULT_SOH,
        FAULT_HDR_SUM,
        FAULT_ADDR,
        FAULT_STX,
        FAULT_ETX,
        FAULT_DATA_SUM,
        FAULT_EOT
    } fault_t;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       m_valid;
    logic       m_ready;
    logic       m_send_ack;
    logic       m_data_valid;
    logic [7:0] m_data_byte;
    logic [7:0] m_data_index;
    logic       m_packet_done;
    logic       m_packet_error;
    logic [2:0] m_error_code;
    logic [7:0] m_source_id;
    logic [7:0] m_function_code;
    logic [8:0] m_payload_length;

    // Receiver tracking state
    phase_t     trk_phase;
    logic [8:0] trk_pos;
    logic [7:0] trk_sum;
    logic [7:0] trk_lead;
    logic [7:0] hdr_dest;
    logic [7:0] hdr_src;
    logic [7:0] hdr_func;
    logic [7:0] hdr_size;
    logic [7:0] station_shadow;

    result_t replies_due[$];
    int      reply_mismatches = 0;
    int      replies_seen = 0;
    int      packet_items = 0;
    int      burst_left = 0;
    bit      offering = 1'b0;
    int      holdoff_len = 0;

    serial_packet_receiver u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_send_ack       (m_send_ack),
        .m_data_valid     (m_data_valid),
        .m_data_byte      (m_data_byte),
        .m_data_index     (m_data_index),
        .m_packet_done    (m_packet_done),
        .m_packet_error   (m_packet_error),
        .m_error_code     (m_error_code),
        .m_source_id      (m_source_id),
        .m_function_code  (m_function_code),
        .m_payload_length (m_payload_length)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Advance the receiver by one byte and return the reply it must give.
    function automatic result_t decode_rx_byte(input logic [7:0] b);
        result_t    r;
        logic       bad;
        logic [2:0] code;
        r = '0;
        bad = 1'b0;
        code = ERR_BAD_SOH;
        case (trk_phase)
            PH_HEADER: begin
                if (trk_pos == 9'd0) begin
                    trk_lead = b;
                    trk_sum = 8'd0;
                end
                trk_sum = trk_sum + b;
                case (trk_pos)
                    POS_DEST:   hdr_dest = b;
                    POS_SOURCE: hdr_src = b;
                    POS_FUNC:   hdr_func = b;
                    POS_SIZE:   hdr_size = b;
                    default: ;
                endcase
                trk_pos = trk_pos + 9'd1;
                if (trk_pos > HEADER_LAST) begin
                    if (trk_lead != CH_SOH) begin
                        bad = 1'b1;
                        code = ERR_BAD_SOH;
                    end else if (trk_sum != 8'd0) begin
                        bad = 1'b1;
                        code = ERR_HDR_SUM;
                    end else if (hdr_dest != station_shadow) begin
                        bad = 1'b1;
                        code = ERR_NOT_ADDR;
                    end else begin
                        r.send_ack = 1'b1;
                        trk_phase = PH_DATA;
                        trk_pos = 9'd0;
                    end
                end
            end
            PH_DATA: begin
                if (trk_pos == 9'd0) begin
                    trk_lead = b;
                    trk_sum = 8'd0;
                end else begin
                    r.data_valid = 1'b1;
                    r.data_byte = b;
                    r.data_index = 8'(trk_pos - 9'd1);
                end
                trk_sum = trk_sum + b;
                trk_pos = trk_pos + 9'd1;
                // a bad STX still lets the payload through; report it at the end
                if (trk_pos >= 9'(hdr_size) + 9'd2) begin
                    if (trk_lead != CH_STX) begin
                        bad = 1'b1;
                        code = ERR_BAD_STX;
                    end else begin
                        trk_phase = PH_CHECK;
                        trk_pos = 9'd0;
                    end
                end
            end
            PH_CHECK: begin
                if (trk_pos == 9'd0)
                    trk_lead = b;
                trk_sum = trk_sum + b;
                trk_pos = trk_pos + 9'd1;
                if (trk_pos >= 9'd2) begin
                    if (trk_lead != CH_ETX) begin
                        bad = 1'b1;
                        code = ERR_BAD_ETX;
                    end else if (trk_sum != 8'd0) begin
                        bad = 1'b1;
                        code = ERR_DATA_SUM;
                    end else begin
                        trk_phase = PH_TRAILER;
                        trk_pos = 9'd0;
                    end
                end
            end
            PH_TRAILER: begin
                if (b != CH_EOT) begin
                    bad = 1'b1;
                    code = ERR_BAD_EOT;
                end else begin
                    r.send_ack = 1'b1;
                    r.packet_done = 1'b1;
                    r.source_id = hdr_src;
                    r.function_code = hdr_func;
                    r.payload_length = 9'(hdr_size) + 9'd1;
                    trk_phase = PH_IDLE;
                    trk_pos = 9'd0;
                end
            end
            default: begin
                if (b == CH_ENQ) begin
                    r.send_ack = 1'b1;
                    trk_phase = PH_HEADER;
                    trk_pos = 9'd0;
                end else begin
                    trk_phase = PH_IDLE;
                end
            end
        endcase
        if (bad) begin
            r.packet_error = 1'b1;
            r.error_code = code;
            trk_phase = PH_IDLE;
            trk_pos = 9'd0;
        end
        return r;
    endfunction

    function automatic string format_reply(input result_t r);
        return $sformatf({"ack=%0b dv=%0b byte=%02h idx=%0d done=%0b err=%0b code=%0d ",
                          "src=%02h func=%02h len=%0d"},
                         r.send_ack, r.data_valid, r.data_byte, r.data_index,
                         r.packet_done, r.packet_error, r.error_code,
                         r.source_id, r.function_code, r.payload_length);
    endfunction

    function automatic logic [7:0] flip_some(input logic [7:0] v);
        return v ^ 8'($urandom_range(1, 255));
    endfunction

    always @(posedge aclk) begin : reply_check
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_send_ack, m_data_valid, m_data_byte, m_data_index, m_packet_done,
                   m_packet_error, m_error_code, m_source_id, m_function_code,
                   m_payload_length};
            if (replies_due.size() == 0) begin
                reply_mismatches++;
                if (reply_mismatches <= 10)
                    $display("reply %0d not expected: %s", replies_seen, format_reply(got));
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    reply_mismatches++;
                    if (reply_mismatches <= 10) begin
                        $display("reply %0d mismatch", replies_seen);
                        $display("  expected %s", format_reply(want));
                        $display("  actual   %s", format_reply(got));
                    end
                end
            end
            replies_seen++;
        end
    end

    // Result side: stretches of open flow, random stalls and rotating patterns,
    // plus a long hold-off on request.
    initial begin : result_sink
        sink_mode_t  mode;
        int          mode_left;
        logic [15:0] pattern;
        m_ready = 1'b0;
        mode = SINK_OPEN;
        mode_left = 0;
        pattern = 16'hFFFF;
        forever begin
            @(posedge aclk);
            if (holdoff_len > 0) begin
                m_ready <= 1'b0;
                repeat (holdoff_len) @(posedge aclk);
                holdoff_len = 0;
                m_ready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 400);
                    pattern = 16'($urandom) | 16'h0001;
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_RANDOM: m_ready <= ($urandom_range(0, 99) < 60);
                    default: begin
                        m_ready <= pattern[0];
                        pattern = {pattern[0], pattern[15:1]};
                    end
                endcase
            end
        end
    end

    // Offer one byte, hold it until accepted, then maybe open a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_valid <= 1'b1;
        s_rx_byte <= b;
        offering = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replies_due.push_back(decode_rx_byte(b));
        if (burst_left <= 1) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_replies();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_station(input logic [7:0] id);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data <= id;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        station_shadow = id;
    endtask

    // Build one framed packet (ENQ, header, data, check, trailer) with an optional fault.
    task automatic send_frame(input fault_t fault, input logic [7:0] size);
        logic [7:0] frame[$];
        logic [7:0] sum;
        logic [7:0] chk;
        logic [7:0] b;
        int         i;
        frame.push_back(CH_ENQ);
        frame.push_back(fault == FAULT_SOH ? flip_some(CH_SOH) : CH_SOH);
        frame.push_back(8'($urandom));
        frame.push_back(fault == FAULT_ADDR ? flip_some(station_shadow) : station_shadow);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(size);
        sum = 8'd0;
        for (i = 1; i < 7; i++)
            sum = sum + frame[i];
        chk = -sum;
        frame.push_back(fault == FAULT_HDR_SUM ? flip_some(chk) : chk);
        frame.push_back(fault == FAULT_STX ? flip_some(CH_STX) : CH_STX);
        sum = frame[$];
        for (i = 0; i <= int'(size); i++) begin
            b = 8'($urandom);
            frame.push_back(b);
            sum = sum + b;
        end
        frame.push_back(fault == FAULT_ETX ? flip_some(CH_ETX) : CH_ETX);
        sum = sum + frame[$];
        chk = -sum;
        frame.push_back(fault == FAULT_DATA_SUM ? flip_some(chk) : chk);
        frame.push_back(fault == FAULT_EOT ? flip_some(CH_EOT) : CH_EOT);
        foreach (frame[k]) begin
            send_byte(frame[k]);
            packet_items++;
        end
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_SOH);
        send_byte(CH_EOT);
    endtask

    task automatic test_shortest_packet();
        send_frame(FAULT_NONE, 8'd0);
    endtask

    task automatic test_bad_header_start();
        send_frame(FAULT_SOH, 8'd0);
    endtask

    task automatic test_longest_payload();
        send_frame(FAULT_NONE, 8'hFF);
    endtask

    // Hold the result side off so the block fills and stalls its input.
    task automatic test_input_backpressure();
        holdoff_len = 120;
        send_frame(FAULT_NONE, 8'd40);
    endtask

    // About half well-formed packets, the rest carrying one fault each, with line noise between.
    task automatic test_random_traffic(input int n_items);
        int     target;
        int     pick;
        fault_t fault;
        logic [7:0] size;
        target = packet_items + n_items;
        while (packet_items < target) begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            if ($urandom_range(0, 1) == 0)
                fault = FAULT_NONE;
            else
                fault = fault_t'($urandom_range(1, 7));
            pick = $urandom_range(0, 39);
            if (pick == 0)
                size = 8'hFF;
            else if (pick < 5)
                size = 8'($urandom_range(16, 80));
            else
                size = 8'($urandom_range(0, 15));
            send_frame(fault, size);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_data = 8'h00;
        trk_phase = PH_IDLE;
        trk_pos = 9'd0;
        trk_sum = 8'd0;
        trk_lead = 8'd0;
        hdr_dest = 8'd0;
        hdr_src = 8'd0;
        hdr_func = 8'd0;
        hdr_size = 8'd0;
        station_shadow = 8'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_bytes();
        test_shortest_packet();
        test_bad_header_start();

        write_station(8'hFF);
        test_longest_payload();
        test_random_traffic(290);

        write_station(8'($urandom));
        test_input_backpressure();
        test_random_traffic(290);

        write_station(8'h00);
        test_random_traffic(290);

        write_station(8'($urandom));
        test_random_traffic(290);

        drain_replies();
        repeat (8) @(posedge aclk);
        if (reply_mismatches == 0 && replies_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
